FILE: design/hnv_pkg.sv
`default_nettype none

package hnv_pkg;

    // grid geometry
    localparam int GRID_SIZE = 64;
    localparam int COORD_W   = $clog2(GRID_SIZE);

    // field widths
    localparam int HEIGHT_W  = 24;
    localparam int SPACING_W = 24;
    localparam int NORM_W    = 16;
    localparam int IDX_W     = 10;

    localparam logic [SPACING_W-1:0] SPACING_RESET = SPACING_W'(256);

    // normalization datapath
    localparam int FRAC_BITS = 14;
    localparam int ONE_Q14   = 1 << FRAC_BITS;
    localparam int DIFF_W    = HEIGHT_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int L2_W      = PROD_W + 1;
    localparam int ROOT_W    = 26;
    localparam int ROOT_TOP  = 2 * (ROOT_W - 1);
    localparam int QUOT_W    = FRAC_BITS + 1;
    localparam int NUM_W     = DIFF_W + FRAC_BITS + 1;
    localparam int CNT_W     = $clog2(QUOT_W);
    localparam int LANES     = 3;

    typedef enum logic {
        JOB_BORDER,
        JOB_SURFACE
    } t_job_kind;

    // one normal to be produced by the back end
    typedef struct packed {
        t_job_kind                 kind;
        logic signed [DIFF_W-1:0]  x;
        logic        [DIFF_W-1:0]  y;
        logic signed [DIFF_W-1:0]  z;
        logic        [IDX_W-1:0]   col;
        logic        [IDX_W-1:0]   row;
        logic                      done;
    } t_job;

    typedef enum logic [2:0] {
        F_IDLE,
        F_RD_L,
        F_RD_U,
        F_RD_R,
        F_RD_C,
        F_WR,
        F_PUSH_A,
        F_PUSH_B
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SQX,
        B_SQY,
        B_SQZ,
        B_SUM,
        B_ROOT,
        B_PREP,
        B_DIV
    } t_back_state;

    localparam t_back_state B_EMIT_HOLD = B_IDLE;

endpackage

`default_nettype wire

FILE: design/hnv_ifs.sv
`default_nettype none

interface hnv_in_if import hnv_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [HEIGHT_W-1:0]  height_sample;

    modport source (output valid, output height_sample, input ready);
    modport sink   (input valid, input height_sample, output ready);
endinterface

interface hnv_out_if import hnv_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [NORM_W-1:0]    normal_x;
    logic signed [NORM_W-1:0]    normal_y;
    logic signed [NORM_W-1:0]    normal_z;
    logic        [IDX_W-1:0]     column_index;
    logic        [IDX_W-1:0]     row_index;
    logic                        grid_done;

    modport source (output valid, output normal_x, output normal_y, output normal_z,
                    output column_index, output row_index, output grid_done,
                    input ready);
    modport sink   (input valid, input normal_x, input normal_y, input normal_z,
                    input column_index, input row_index, input grid_done,
                    output ready);
endinterface

`default_nettype wire

FILE: design/hnv_front.sv
`default_nettype none

module hnv_front import hnv_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    hnv_in_if.sink                     i_height,
    input  wire logic [SPACING_W-1:0]  i_grid_spacing,
    output t_job                       o_job,
    output logic                       o_job_valid,
    input  wire logic                  i_job_ready
);

    t_front_state r_state, n_state;
    logic [COORD_W-1:0] r_col, n_col;
    logic [COORD_W-1:0] r_row, n_row;
    logic signed [HEIGHT_W-1:0] r_h, n_h;
    logic signed [HEIGHT_W-1:0] r_hl, n_hl;
    logic signed [HEIGHT_W-1:0] r_hu, n_hu;
    logic signed [HEIGHT_W-1:0] r_hr, n_hr;

    // line stores, read data registered
    logic signed [HEIGHT_W-1:0] mem_older [GRID_SIZE];
    logic signed [HEIGHT_W-1:0] mem_newer [GRID_SIZE];
    logic signed [HEIGHT_W-1:0] r_older_rd;
    logic signed [HEIGHT_W-1:0] r_newer_rd;
    logic [COORD_W-1:0] older_addr;
    logic [COORD_W-1:0] newer_addr;
    logic               store_we;

    logic last_col;
    logic last_row;
    logic surface;

    assign last_col = (r_col == COORD_W'(GRID_SIZE - 1));
    assign last_row = (r_row == COORD_W'(GRID_SIZE - 1));
    assign surface  = (r_row >= COORD_W'(2)) && (r_col != '0) && !last_col;

    // state and position registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
        end
        r_h  <= n_h;
        r_hl <= n_hl;
        r_hu <= n_hu;
        r_hr <= n_hr;
    end

    // line store access
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            mem_older[r_col] <= r_newer_rd;
            mem_newer[r_col] <= r_h;
        end
        r_older_rd <= mem_older[older_addr];
        r_newer_rd <= mem_newer[newer_addr];
    end

    // sequencer: read neighbours, shift the stores, hand jobs to the queue
    always_comb begin
        n_state      = r_state;
        n_col        = r_col;
        n_row        = r_row;
        n_h          = r_h;
        n_hl         = r_hl;
        n_hu         = r_hu;
        n_hr         = r_hr;
        older_addr   = r_col;
        newer_addr   = r_col;
        store_we     = 1'b0;
        i_height.ready = 1'b0;
        o_job_valid  = 1'b0;
        o_job        = '0;
        o_job.kind   = JOB_BORDER;
        o_job.col    = IDX_W'(r_col);
        o_job.row    = IDX_W'(r_row);

        case (r_state)
            F_IDLE: begin
                i_height.ready = 1'b1;
                if (i_height.valid) begin
                    n_h     = i_height.height_sample;
                    n_state = F_RD_L;
                end
            end
            F_RD_L: begin
                older_addr = r_col - COORD_W'(1);
                n_state    = F_RD_U;
            end
            F_RD_U: begin
                n_hl       = r_older_rd;
                older_addr = r_col;
                n_state    = F_RD_R;
            end
            F_RD_R: begin
                n_hu       = r_older_rd;
                newer_addr = r_col + COORD_W'(1);
                n_state    = F_RD_C;
            end
            F_RD_C: begin
                n_hr       = r_newer_rd;
                newer_addr = r_col;
                n_state    = F_WR;
            end
            F_WR: begin
                store_we = 1'b1;
                n_state  = F_PUSH_A;
            end
            F_PUSH_A: begin
                // normal of the vertex one row up
                o_job.row = IDX_W'(r_row - COORD_W'(1));
                if (surface) begin
                    o_job.kind = JOB_SURFACE;
                    o_job.x    = DIFF_W'(r_hl) - DIFF_W'(r_hr);
                    o_job.y    = {i_grid_spacing, 1'b0};
                    o_job.z    = DIFF_W'(r_hu) - DIFF_W'(r_h);
                end
                o_job_valid = (r_row != '0);
                if (r_row == '0 || i_job_ready) begin
                    n_state = last_row ? F_PUSH_B : F_IDLE;
                    if (!last_row) begin
                        n_col = last_col ? '0 : r_col + COORD_W'(1);
                        n_row = last_col ? r_row + COORD_W'(1) : r_row;
                    end
                end
            end
            F_PUSH_B: begin
                // border normal of the last row itself
                o_job.done  = last_col;
                o_job_valid = 1'b1;
                if (i_job_ready) begin
                    n_state = F_IDLE;
                    n_col   = last_col ? '0 : r_col + COORD_W'(1);
                    n_row   = last_col ? '0 : r_row;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/hnv_queue.sv
`default_nettype none

module hnv_queue import hnv_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  t_job       i_push_job,
    input  wire logic  i_push_valid,
    output logic       o_push_ready,
    output t_job       o_pop_job,
    output logic       o_pop_valid,
    input  wire logic  i_pop_ready
);

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_job    = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // two-entry job queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
        if (push) begin
            r_mem[r_wp] <= i_push_job;
        end
    end

endmodule

`default_nettype wire

FILE: design/hnv_back.sv
`default_nettype none

module hnv_back import hnv_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  t_job       i_job,
    input  wire logic  i_job_valid,
    output logic       o_job_ready,
    hnv_out_if.source  o_normal
);

    t_back_state r_state, n_state;
    t_job        r_job, n_job;
    logic        r_emit, n_emit;
    logic        r_zero, n_zero;

    logic [PROD_W-1:0]  r_prod, n_prod;
    logic [L2_W-1:0]    r_acc, n_acc;
    logic [L2_W-1:0]    r_x, n_x;
    logic [L2_W-1:0]    r_root, n_root;
    logic [L2_W-1:0]    r_bit, n_bit;
    logic [ROOT_W-1:0]  r_rem  [LANES];
    logic [ROOT_W-1:0]  n_rem  [LANES];
    logic [QUOT_W-1:0]  r_num  [LANES];
    logic [QUOT_W-1:0]  n_num  [LANES];
    logic [QUOT_W-1:0]  r_quot [LANES];
    logic [QUOT_W-1:0]  n_quot [LANES];
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    // output register
    logic                    r_out_valid, n_out_valid;
    logic signed [NORM_W-1:0] r_nx, n_nx, r_ny, n_ny, r_nz, n_nz;
    logic [IDX_W-1:0]        r_ci, n_ci, r_ri, n_ri;
    logic                    r_done, n_done;

    logic [DIFF_W-1:0] mag [LANES];
    logic [DIFF_W-1:0] mul_a;
    logic [L2_W-1:0]   l2_sum;
    logic [L2_W:0]     trial;
    logic [NUM_W-1:0]  num;
    logic [ROOT_W:0]   shifted;
    logic [ROOT_W-1:0] len;
    logic              out_free;
    logic signed [NORM_W-1:0] comp [LANES];

    assign mag[0] = r_job.x[DIFF_W-1] ? DIFF_W'(-r_job.x) : DIFF_W'(r_job.x);
    assign mag[1] = r_job.y;
    assign mag[2] = r_job.z[DIFF_W-1] ? DIFF_W'(-r_job.z) : DIFF_W'(r_job.z);
    assign len    = r_root[ROOT_W-1:0];
    assign l2_sum = r_acc + L2_W'(r_prod);
    assign trial  = (L2_W+1)'(r_root) + (L2_W+1)'(r_bit);
    assign out_free = !r_out_valid || o_normal.ready;

    assign o_normal.valid        = r_out_valid;
    assign o_normal.normal_x     = r_nx;
    assign o_normal.normal_y     = r_ny;
    assign o_normal.normal_z     = r_nz;
    assign o_normal.column_index = r_ci;
    assign o_normal.row_index    = r_ri;
    assign o_normal.grid_done    = r_done;

    // signed components from the quotients
    always_comb begin
        comp[0] = r_job.x[DIFF_W-1] ? -NORM_W'(r_quot[0]) : NORM_W'(r_quot[0]);
        comp[1] = NORM_W'(r_quot[1]);
        comp[2] = r_job.z[DIFF_W-1] ? -NORM_W'(r_quot[2]) : NORM_W'(r_quot[2]);
    end

    // shared squarer operand
    always_comb begin
        case (r_state)
            B_SQY:   mul_a = mag[1];
            B_SQZ:   mul_a = mag[2];
            default: mul_a = mag[0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_emit      <= n_emit;
            r_out_valid <= n_out_valid;
        end
        r_job  <= n_job;
        r_zero <= n_zero;
        r_prod <= n_prod;
        r_acc  <= n_acc;
        r_x    <= n_x;
        r_root <= n_root;
        r_bit  <= n_bit;
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_num  <= n_num;
        r_quot <= n_quot;
        r_nx   <= n_nx;
        r_ny   <= n_ny;
        r_nz   <= n_nz;
        r_ci   <= n_ci;
        r_ri   <= n_ri;
        r_done <= n_done;
    end

    // squares, root, three dividers, then the output register (border jobs and zero-length sums skip to it)
    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_emit      = r_emit;
        n_zero      = r_zero;
        n_prod      = r_prod;
        n_acc       = r_acc;
        n_x         = r_x;
        n_root      = r_root;
        n_bit       = r_bit;
        n_cnt       = r_cnt;
        n_rem       = r_rem;
        n_num       = r_num;
        n_quot      = r_quot;
        n_out_valid = r_out_valid && !o_normal.ready;
        n_nx        = r_nx;
        n_ny        = r_ny;
        n_nz        = r_nz;
        n_ci        = r_ci;
        n_ri        = r_ri;
        n_done      = r_done;
        o_job_ready = 1'b0;
        num         = '0;
        shifted     = '0;

        case (r_state)
            B_IDLE: begin
                if (r_emit) begin
                    // result waits for the output register
                    if (out_free) begin
                        n_emit      = 1'b0;
                        n_out_valid = 1'b1;
                        n_ci        = r_job.col;
                        n_ri        = r_job.row;
                        n_done      = r_job.done;
                        if (r_job.kind == JOB_BORDER) begin
                            n_nx = '0;
                            n_ny = NORM_W'(ONE_Q14);
                            n_nz = '0;
                        end else if (r_zero) begin
                            n_nx = '0;
                            n_ny = '0;
                            n_nz = '0;
                        end else begin
                            n_nx = comp[0];
                            n_ny = comp[1];
                            n_nz = comp[2];
                        end
                    end
                end else begin
                    o_job_ready = 1'b1;
                    if (i_job_valid) begin
                        n_job = i_job;
                        if (i_job.kind == JOB_BORDER) begin
                            n_emit = 1'b1;
                        end else begin
                            n_state = B_SQX;
                        end
                    end
                end
            end
            B_SQX: begin
                n_prod  = mul_a * mul_a;
                n_state = B_SQY;
            end
            B_SQY: begin
                n_acc   = L2_W'(r_prod);
                n_prod  = mul_a * mul_a;
                n_state = B_SQZ;
            end
            B_SQZ: begin
                n_acc   = l2_sum;
                n_prod  = mul_a * mul_a;
                n_state = B_SUM;
            end
            B_SUM: begin
                n_zero = (l2_sum == '0);
                n_x    = l2_sum;
                n_root = '0;
                n_bit  = L2_W'(1) << ROOT_TOP;
                if (l2_sum == '0) begin
                    n_state = B_IDLE;
                    n_emit  = 1'b1;
                end else begin
                    n_state = B_ROOT;
                end
            end
            B_ROOT: begin
                // one result bit per cycle
                if ((L2_W+1)'(r_x) >= trial) begin
                    n_x    = r_x - L2_W'(trial);
                    n_root = (r_root >> 1) + r_bit;
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit[0]) begin
                    n_state = B_PREP;
                end
            end
            B_PREP: begin
                // dividend is |c| * 2^14 + len/2, top bits start the remainder
                for (int i = 0; i < LANES; i++) begin
                    num      = {mag[i], FRAC_BITS'(0)} + NUM_W'(len >> 1);
                    n_rem[i] = ROOT_W'(num[NUM_W-1:QUOT_W]);
                    n_num[i] = num[QUOT_W-1:0];
                    n_quot[i] = '0;
                end
                n_cnt   = '0;
                n_state = B_DIV;
            end
            B_DIV: begin
                // restoring division, one quotient bit per lane per cycle
                for (int i = 0; i < LANES; i++) begin
                    shifted = {r_rem[i], r_num[i][QUOT_W-1]};
                    if (shifted >= {1'b0, len}) begin
                        n_rem[i]  = ROOT_W'(shifted - {1'b0, len});
                        n_quot[i] = {r_quot[i][QUOT_W-2:0], 1'b1};
                    end else begin
                        n_rem[i]  = ROOT_W'(shifted);
                        n_quot[i] = {r_quot[i][QUOT_W-2:0], 1'b0};
                    end
                    n_num[i] = r_num[i] << 1;
                end
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(QUOT_W - 1)) begin
                    n_state = B_EMIT_HOLD;
                    n_emit  = 1'b1;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/heightmap_normal_vectors.sv
// channel     dir  handshake               payload
// i_height    in   valid/ready             height_sample (s24, Q16.8)
// o_normal    out  valid/ready             normal_x/y/z (s16, Q1.14), column_index,
//                                          row_index, grid_done
// cfg         in   i_cfg_we, no stall      i_cfg_wdata = grid_spacing (u24, Q16.8)
//
// the front end takes a new item only when done with the last, which queue stalls
// can delay: four line store reads, one write, and one job push per normal (two
// on the last grid row); border normals pass from the job register to the
// output register; interior ones first pass the squares, the 26-step square
// root and the 15-step dividers (three lanes in parallel), zero-length ones only
// the squares; a full output register holds the back end, which then stops taking jobs
// a two-job queue lets the front end run ahead of the back end
// synchronous active-low reset; grid position to zero, spacing to 256

`default_nettype none

module heightmap_normal_vectors import hnv_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    hnv_in_if.sink                     i_height,
    hnv_out_if.source                  o_normal,
    input  wire logic                  i_cfg_we,
    input  wire logic [SPACING_W-1:0]  i_cfg_wdata
);

    logic [SPACING_W-1:0] r_grid_spacing;

    t_job f_job, q_job;
    logic f_valid, f_ready, q_valid, q_ready;

    // spacing register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_spacing <= SPACING_RESET;
        end else if (i_cfg_we) begin
            r_grid_spacing <= i_cfg_wdata;
        end
    end

    hnv_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_height       (i_height),
        .i_grid_spacing (r_grid_spacing),
        .o_job          (f_job),
        .o_job_valid    (f_valid),
        .i_job_ready    (f_ready)
    );

    hnv_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_job   (f_job),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .o_pop_job    (q_job),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready)
    );

    hnv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (q_job),
        .i_job_valid (q_valid),
        .o_job_ready (q_ready),
        .o_normal    (o_normal)
    );

endmodule

`default_nettype wire

FILE: tb/sv/tb_heightmap_normal_vectors.sv
`default_nettype none

module tb_heightmap_normal_vectors;
    import hnv_pkg::*;

    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nz;
        logic [IDX_W-1:0]         col;
        logic [IDX_W-1:0]         row;
        logic                     done;
    } t_normal;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [SPACING_W-1:0] i_cfg_wdata = '0;

    hnv_in_if  height_ch ();
    hnv_out_if normal_ch ();

    heightmap_normal_vectors dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_height    (height_ch.sink),
        .o_normal    (normal_ch.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    logic signed [HEIGHT_W-1:0] prior_row [GRID_SIZE] = '{default: '0};
    logic signed [HEIGHT_W-1:0] latest_row [GRID_SIZE] = '{default: '0};
    int unsigned grid_col = 0;
    int unsigned grid_row = 0;
    logic [SPACING_W-1:0] spacing = SPACING_RESET;

    logic signed [HEIGHT_W-1:0] pending_heights [$];
    t_normal expected_normals [$];
    int  mismatches = 0;
    bit  hold_sink = 1'b0;
    bit  feed_done = 1'b0;

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [NORM_W-1:0] unit_comp(longint c, longint unsigned len);
        longint unsigned m;
        longint unsigned q;
        m = (c < 0) ? longint'(-c) : c;
        q = (m * ONE_Q14 + len / 2) / len;
        if (c < 0) q = -q;
        return q[NORM_W-1:0];
    endfunction

    function automatic t_normal border_normal(int unsigned c, int unsigned r, bit d);
        t_normal n;
        n.nx = '0;
        n.ny = NORM_W'(ONE_Q14);
        n.nz = '0;
        n.col = IDX_W'(c);
        n.row = IDX_W'(r);
        n.done = d;
        return n;
    endfunction

    // expected normals caused by one height item
    task automatic predict_normals(logic signed [HEIGHT_W-1:0] h);
        longint x, y, z;
        longint unsigned l2, len;
        t_normal n;
        if (grid_row >= 1) begin
            if (grid_row >= 2 && grid_col >= 1 && grid_col + 1 < GRID_SIZE) begin
                x = longint'(prior_row[grid_col-1]) - longint'(latest_row[grid_col+1]);
                y = 2 * longint'(spacing);
                z = longint'(prior_row[grid_col]) - longint'(h);
                l2 = x * x + y * y + z * z;
                n.col = IDX_W'(grid_col);
                n.row = IDX_W'(grid_row - 1);
                n.done = 1'b0;
                if (l2 == 0) begin
                    n.nx = '0; n.ny = '0; n.nz = '0;
                end else begin
                    len = int_sqrt(l2);
                    n.nx = unit_comp(x, len);
                    n.ny = unit_comp(y, len);
                    n.nz = unit_comp(z, len);
                end
                expected_normals.insert(expected_normals.size(), n);
            end else begin
                expected_normals.insert(expected_normals.size(),
                                        border_normal(grid_col, grid_row - 1, 1'b0));
            end
        end
        if (grid_row == GRID_SIZE - 1)
            expected_normals.insert(expected_normals.size(),
                                    border_normal(grid_col, grid_row,
                                                  grid_col == GRID_SIZE - 1));
        prior_row[grid_col] = latest_row[grid_col];
        latest_row[grid_col] = h;
        grid_col++;
        if (grid_col >= GRID_SIZE) begin
            grid_col = 0;
            grid_row = (grid_row + 1 >= GRID_SIZE) ? 0 : grid_row + 1;
        end
    endtask

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // height driver
    int src_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            height_ch.valid <= 1'b0;
            height_ch.height_sample <= '0;
        end else if (height_ch.valid && !height_ch.ready) begin
            // hold the offered item
        end else begin
            if (height_ch.valid) begin
                predict_normals(height_ch.height_sample);
                void'(pending_heights.pop_front());
            end
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                height_ch.valid <= 1'b0;
            end else if (pending_heights.size() > 0) begin
                height_ch.valid <= 1'b1;
                height_ch.height_sample <= pending_heights[0];
                src_gap <= gap_len();
            end else begin
                height_ch.valid <= 1'b0;
            end
        end
    end

    // normal monitor and receiver stalls
    int sink_gap = 0;
    always @(posedge i_clk) begin
        t_normal got, want;
        if (!i_rst_n) begin
            normal_ch.ready <= 1'b0;
        end else begin
            if (normal_ch.valid && normal_ch.ready) begin
                got = '{normal_ch.normal_x, normal_ch.normal_y, normal_ch.normal_z,
                        normal_ch.column_index, normal_ch.row_index, normal_ch.grid_done};
                if (expected_normals.size() == 0) begin
                    $display("%0t: unexpected normal %p", $time, got);
                    mismatches++;
                end else begin
                    want = expected_normals.pop_front();
                    if (got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz ||
                        got.col !== want.col || got.row !== want.row ||
                        got.done !== want.done) begin
                        $display("%0t: normal mismatch expected %p actual %p",
                                 $time, want, got);
                        mismatches++;
                    end
                end
            end
            if (hold_sink) begin
                normal_ch.ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                normal_ch.ready <= 1'b0;
            end else begin
                normal_ch.ready <= 1'b1;
                sink_gap <= gap_len();
            end
        end
    end

    task automatic wait_drained();
        while (pending_heights.size() != 0 || height_ch.valid ||
               expected_normals.size() != 0)
            @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_spacing(logic [SPACING_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        spacing = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // a run of heights; mode picks the terrain style
    task automatic queue_heights(int mode, int count);
        int base;
        logic signed [HEIGHT_W-1:0] h;
        base = $urandom_range(0, 4000) - 2000;
        for (int i = 0; i < count; i++) begin
            case (mode)
                0: h = HEIGHT_W'($urandom);
                1: h = HEIGHT_W'(base + $urandom_range(0, 600) - 300);
                2: h = HEIGHT_W'(0);
                default: h = ($urandom_range(0, 1) != 0) ? 24'h7fffff : 24'h800000;
            endcase
            pending_heights.insert(pending_heights.size(), h);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default spacing, smooth terrain, with a long receiver hold-off
        queue_heights(1, 180);
        repeat (900) @(posedge i_clk);
        hold_sink <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_sink <= 1'b0;
        wait_drained();

        // zero spacing on flat rows gives zero-length normals
        write_spacing('0);
        queue_heights(2, 200);
        wait_drained();

        // full-scale heights, max spacing
        write_spacing(24'hffffff);
        queue_heights(3, 100);
        wait_drained();

        // random heights and spacing
        write_spacing(SPACING_W'($urandom_range(1, 4096)));
        queue_heights(0, 70);
        wait_drained();

        write_spacing(24'd1);
        queue_heights(0, 50);
        wait_drained();

        write_spacing(SPACING_W'($urandom));
        queue_heights(1, 50);
        wait_drained();

        if (mismatches == 0) begin
            $display("heightmap_normal_vectors regression: pass");
        end else begin
            $display("heightmap_normal_vectors regression: fail");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("heightmap_normal_vectors regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
